[hw/rtl/fftmp_pkg.sv]
// ----------------------------------------------------------------------------
// fftmp_pkg
// Shared types, constants and tables for the FFT magnitude/phase block.
// ----------------------------------------------------------------------------
package fftmp_pkg;

    localparam int DATA_W     = 24;
    localparam int CORDIC_N   = 15;
    localparam int MAX_POINTS = 64;
    localparam logic [2:0] LP_MAX = 3'($clog2(MAX_POINTS));

    // Controller -> datapath commands
    typedef struct packed {
        logic       load;      // write sample into work memory
        logic       bf_rd;     // read butterfly operands
        logic       bf_mul;    // form twiddle products
        logic       bf_wr;     // write butterfly results
        logic       out_rd;    // read bin for output
        logic       out_sq;    // start square-sum of bin
        logic       sq_step;   // one square root digit
        logic       cd_init;   // start phase CORDIC
        logic       cd_step;   // one CORDIC iteration
        logic [5:0] addr_a;
        logic [5:0] addr_b;
        logic [4:0] tw_m;
        logic [3:0] iter;
    } fftmp_cmd_t;

    function automatic logic [15:0] quarter_cos(input logic [4:0] m);
        logic [15:0] r;
        begin
            unique case (m)
                5'd0:  r = 16'd32767; // 32768 handled by caller
                5'd1:  r = 16'd32610;
                5'd2:  r = 16'd32138;
                5'd3:  r = 16'd31357;
                5'd4:  r = 16'd30274;
                5'd5:  r = 16'd28899;
                5'd6:  r = 16'd27246;
                5'd7:  r = 16'd25330;
                5'd8:  r = 16'd23170;
                5'd9:  r = 16'd20788;
                5'd10: r = 16'd18205;
                5'd11: r = 16'd15447;
                5'd12: r = 16'd12540;
                5'd13: r = 16'd9512;
                5'd14: r = 16'd6393;
                5'd15: r = 16'd3212;
                default: r = 16'd0;
            endcase
            return r;
        end
    endfunction

    // Signed Q15 cosine with 1.0 = 32768, index 0..16
    function automatic logic signed [17:0] qcos(input logic [4:0] m);
        begin
            if (m == 5'd0)
                return 18'sd32768;
            return $signed({2'b00, quarter_cos(m)});
        end
    endfunction

    function automatic logic [13:0] atan_units(input logic [3:0] i);
        logic [13:0] r;
        begin
            unique case (i)
                4'd0:  r = 14'd8192;
                4'd1:  r = 14'd4836;
                4'd2:  r = 14'd2555;
                4'd3:  r = 14'd1297;
                4'd4:  r = 14'd651;
                4'd5:  r = 14'd326;
                4'd6:  r = 14'd163;
                4'd7:  r = 14'd81;
                4'd8:  r = 14'd41;
                4'd9:  r = 14'd20;
                4'd10: r = 14'd10;
                4'd11: r = 14'd5;
                4'd12: r = 14'd3;
                4'd13: r = 14'd1;
                4'd14: r = 14'd1;
                default: r = 14'd0;
            endcase
            return r;
        end
    endfunction

endpackage

[hw/rtl/fftmp_datapath.sv]
// ----------------------------------------------------------------------------
// fftmp_datapath
// Work memory, butterfly unit, serial square root and phase CORDIC.
// ----------------------------------------------------------------------------
module fftmp_datapath
    import fftmp_pkg::*;
(
    input  logic                 clk,
    input  fftmp_cmd_t           cmd,
    input  logic signed [15:0]   sample,
    input  logic [2:0]           lp,
    output logic [15:0]          magnitude,
    output logic signed [16:0]   phase_angle
);

    logic signed [DATA_W-1:0] mem_re [MAX_POINTS];
    logic signed [DATA_W-1:0] mem_im [MAX_POINTS];

    logic signed [DATA_W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [DATA_W-1:0] ar2_reg, ai2_reg;
    logic signed [17:0]       wr_reg, ws_reg;
    logic signed [47:0]       p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [DATA_W-1:0] sum_r, sum_i, dif_r, dif_i;

    // Square root / CORDIC state
    logic [47:0]              sq_reg;
    logic [23:0]              root_reg;
    logic [47:0]              rem_reg;
    logic signed [41:0]       cx_reg, cy_reg;
    logic signed [17:0]       cz_reg;
    logic [1:0]               special_reg;   // 0 cordic, 1 fixed
    logic signed [17:0]       fixed_reg;
    logic signed [DATA_W-1:0] bre_reg, bim_reg;
    logic signed [47:0]       mre_reg, mim_reg;

    function automatic logic signed [DATA_W-1:0] sat24(input logic signed [DATA_W+1:0] v);
        begin
            if (v > 26'sd8388607)
                return 24'sd8388607;
            if (v < -26'sd8388608)
                return -24'sd8388608;
            return v[DATA_W-1:0];
        end
    endfunction

    // Memory: one write port pair, reads registered
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mem_re[cmd.addr_a] <= DATA_W'(sample);
            mem_im[cmd.addr_a] <= '0;
        end
        if (cmd.bf_wr)
        begin
            mem_re[cmd.addr_a] <= sum_r;
            mem_im[cmd.addr_a] <= sum_i;
            mem_re[cmd.addr_b] <= dif_r;
            mem_im[cmd.addr_b] <= dif_i;
        end
        if (cmd.bf_rd)
        begin
            ar_reg <= mem_re[cmd.addr_a];
            ai_reg <= mem_im[cmd.addr_a];
            br_reg <= mem_re[cmd.addr_b];
            bi_reg <= mem_im[cmd.addr_b];
            if (cmd.tw_m <= 5'd16)
            begin
                wr_reg <= qcos(cmd.tw_m);
                ws_reg <= qcos(5'd16 - cmd.tw_m);
            end
            else
            begin
                wr_reg <= -qcos(5'd0 - cmd.tw_m);
                ws_reg <= qcos(cmd.tw_m - 5'd16);
            end
        end
        if (cmd.out_rd)
        begin
            bre_reg <= mem_re[cmd.addr_a];
            bim_reg <= mem_im[cmd.addr_a];
        end
    end

    // Twiddle products, one register stage
    always_ff @(posedge clk)
    begin
        if (cmd.bf_mul)
        begin
            p1_reg  <= 48'(br_reg * wr_reg);
            p2_reg  <= 48'(bi_reg * ws_reg);
            p3_reg  <= 48'(bi_reg * wr_reg);
            p4_reg  <= 48'(br_reg * ws_reg);
            ar2_reg <= ar_reg;
            ai2_reg <= ai_reg;
        end
    end

    logic signed [47:0] tr_full, ti_full;
    assign tr_full = (p1_reg + p2_reg + 48'sd16384) >>> 15;
    assign ti_full = (p3_reg - p4_reg + 48'sd16384) >>> 15;
    assign sum_r = sat24(26'(ar2_reg) + 26'(tr_full));
    assign sum_i = sat24(26'(ai2_reg) + 26'(ti_full));
    assign dif_r = sat24(26'(ar2_reg) - 26'(tr_full));
    assign dif_i = sat24(26'(ai2_reg) - 26'(ti_full));

    // Square products of the bin
    always_ff @(posedge clk)
    begin
        if (cmd.out_sq)
        begin
            mre_reg <= 48'(bre_reg * bre_reg);
            mim_reg <= 48'(bim_reg * bim_reg);
        end
    end

    // Restoring square root, one result bit per step (24 steps)
    logic [49:0] trial;
    assign trial = {rem_reg, sq_reg[47:46]} - {24'd0, root_reg, 2'b01};
    always_ff @(posedge clk)
    begin
        if (cmd.cd_init)
        begin
            sq_reg   <= mre_reg + mim_reg;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (cmd.sq_step)
        begin
            sq_reg <= {sq_reg[45:0], 2'b00};
            if (!trial[49])
            begin
                rem_reg  <= trial[47:0];
                root_reg <= {root_reg[22:0], 1'b1};
            end
            else
            begin
                rem_reg  <= {rem_reg[45:0], sq_reg[47:46]};
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    logic [24:0] mag_w;
    always_comb
    begin
        mag_w = ({1'b0, root_reg} + (25'd1 << (lp - 3'd1))) >> lp;
        if (mag_w > 25'd32768)
            magnitude = 16'd32768 == 16'd0 ? 16'd0 : 16'h8000;
        else
            magnitude = mag_w[15:0];
    end

    // Phase CORDIC, one iteration per step
    logic signed [41:0] shx, shy;
    assign shx = cx_reg >>> cmd.iter;
    assign shy = cy_reg >>> cmd.iter;
    always_ff @(posedge clk)
    begin
        if (cmd.cd_init)
        begin
            special_reg <= 2'd0;
            fixed_reg   <= '0;
            if (bre_reg == '0)
            begin
                special_reg <= 2'd1;
                fixed_reg   <= (bim_reg > 0) ? 18'sd16384 :
                               ((bim_reg < 0) ? -18'sd16384 : 18'sd0);
            end
            else if (bim_reg == '0)
            begin
                special_reg <= 2'd1;
                fixed_reg   <= (bre_reg > 0) ? 18'sd0 : 18'sd32768;
            end
            if (bre_reg < 0)
            begin
                cx_reg <= -$signed({bre_reg, 16'd0});
                cy_reg <= -$signed({bim_reg, 16'd0});
                cz_reg <= (bim_reg >= 0) ? 18'sd32768 : -18'sd32768;
            end
            else
            begin
                cx_reg <= $signed({bre_reg, 16'd0});
                cy_reg <= $signed({bim_reg, 16'd0});
                cz_reg <= '0;
            end
        end
        else if (cmd.cd_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + shy;
                cy_reg <= cy_reg - shx;
                cz_reg <= cz_reg + $signed({4'd0, atan_units(cmd.iter)});
            end
            else
            begin
                cx_reg <= cx_reg - shy;
                cy_reg <= cy_reg + shx;
                cz_reg <= cz_reg - $signed({4'd0, atan_units(cmd.iter)});
            end
        end
    end

    always_comb
    begin
        if (special_reg == 2'd1)
            phase_angle = fixed_reg[16:0];
        else if (cz_reg > 18'sd32768)
            phase_angle = 17'sd32768 == 17'sd0 ? 17'sd0 : 17'h08000;
        else if (cz_reg < -18'sd32768)
            phase_angle = 17'h18000;
        else
            phase_angle = cz_reg[16:0];
    end

endmodule

[hw/rtl/fftmp_ctrl.sv]
// ----------------------------------------------------------------------------
// fftmp_ctrl
// Sequencer: load, butterfly passes, per-bin magnitude and phase.
// ----------------------------------------------------------------------------
module fftmp_ctrl
    import fftmp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic [2:0] cfg_data,
    output logic       cfg_ready,
    input  logic       in_tvalid,
    output logic       in_tready,
    input  logic       out_tready,
    output logic       out_tvalid,
    output logic [5:0] bin_index,
    output logic       last_bin,
    output logic [2:0] lp,
    output fftmp_cmd_t cmd
);

    localparam logic [3:0] S_LOAD = 4'd0, S_BRD = 4'd1, S_BMUL = 4'd2, S_BWR = 4'd3,
                           S_ORD = 4'd4, S_OSQ = 4'd5, S_INIT = 4'd6, S_ITER = 4'd7,
                           S_OUT = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [2:0] lp_reg;
    logic [2:0] lp_new;
    logic [6:0] cnt_reg;
    logic [2:0] stage_reg;
    logic [5:0] bf_reg;
    logic [4:0] it_reg;
    logic [5:0] k_reg;
    logic [6:0] n;

    always_comb
    begin
        priority if (cfg_data < 3'd2)
            lp_new = 3'd2;
        else if (cfg_data > LP_MAX)
            lp_new = LP_MAX;
        else
            lp_new = cfg_data;
    end
    assign lp = lp_reg;
    assign n  = 7'd1 << lp_reg;

    logic [5:0] rev;
    always_comb
    begin
        rev = '0;
        for (int i = 0; i < 6; i++)
            if (i < int'(lp_reg))
                rev[int'(lp_reg) - 1 - i] = cnt_reg[i];
    end

    // Butterfly addressing: stage s, h = 2^s, index t over n/2
    logic [5:0] h, jj, g;
    assign h  = 6'd1 << stage_reg;
    assign jj = bf_reg & (h - 6'd1);
    assign g  = (bf_reg - jj) << 1;

    assign cfg_ready  = (state_reg == S_LOAD);
    assign in_tready  = (state_reg == S_LOAD) && !cfg_valid;
    assign out_tvalid = (state_reg == S_OUT);
    assign bin_index  = k_reg;
    assign last_bin   = (7'(k_reg) == n - 7'd1);

    always_comb
    begin
        cmd = '0;
        cmd.load    = (state_reg == S_LOAD) && in_tvalid && in_tready;
        cmd.bf_rd   = (state_reg == S_BRD);
        cmd.bf_mul  = (state_reg == S_BMUL);
        cmd.bf_wr   = (state_reg == S_BWR);
        cmd.out_rd  = (state_reg == S_ORD);
        cmd.out_sq  = (state_reg == S_OSQ);
        cmd.cd_init = (state_reg == S_INIT);
        cmd.sq_step = (state_reg == S_ITER);
        cmd.cd_step = (state_reg == S_ITER) && (it_reg < 5'd15);
        cmd.iter    = it_reg[3:0];
        cmd.tw_m    = 5'((jj * (7'd32 >> stage_reg)));
        cmd.addr_a  = (state_reg == S_LOAD) ? rev :
                      ((state_reg == S_ORD) ? k_reg : g + jj);
        cmd.addr_b  = g + jj + h;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: if (cmd.load && cnt_reg == n - 7'd1) state_next = S_BRD;
            S_BRD:  state_next = S_BMUL;
            S_BMUL: state_next = S_BWR;
            S_BWR:
                if (7'(bf_reg) == (n >> 1) - 7'd1 && stage_reg == lp_reg - 3'd1)
                    state_next = S_ORD;
                else
                    state_next = S_BRD;
            S_ORD:  state_next = S_OSQ;
            S_OSQ:  state_next = S_INIT;
            S_INIT: state_next = S_ITER;
            S_ITER: if (it_reg == 5'd23) state_next = S_OUT;
            S_OUT:
                if (out_tready)
                    state_next = last_bin ? S_LOAD : S_ORD;
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            lp_reg    <= 3'd6;
            cnt_reg   <= '0;
            stage_reg <= '0;
            bf_reg    <= '0;
            it_reg    <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                lp_reg  <= lp_new;
                cnt_reg <= '0;
            end
            else if (cmd.load)
                cnt_reg <= (cnt_reg == n - 7'd1) ? 7'd0 : cnt_reg + 7'd1;
            if (state_reg == S_BWR)
            begin
                if (7'(bf_reg) == (n >> 1) - 7'd1)
                begin
                    bf_reg    <= '0;
                    stage_reg <= (state_next == S_ORD) ? 3'd0 : stage_reg + 3'd1;
                end
                else
                    bf_reg <= bf_reg + 6'd1;
            end
            if (state_reg == S_INIT)
                it_reg <= '0;
            else if (state_reg == S_ITER)
                it_reg <= it_reg + 5'd1;
            if (state_reg == S_OUT && out_tready)
                k_reg <= last_bin ? 6'd0 : k_reg + 6'd1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid && $stable(k_reg))
        else $error("bin changed under stall");
    assert property (@(posedge clk) disable iff (!rst_n)
        in_tready |-> !out_tvalid)
        else $error("load during output");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bf_wr |-> stage_reg < lp_reg)
        else $error("stage overrun");

endmodule

[hw/rtl/fft_magnitude_phase.sv]
// ----------------------------------------------------------------------------
// fft_magnitude_phase
// Radix-2 FFT of a frame of real Q15 samples, one magnitude/phase per bin.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_axis    in   tdata[15:0] sample
// m_axis    out  tdata[15:0] magnitude, [32:16] phase_angle, tuser bin_index, tlast
// cfg       in   cfg_data[2:0] log2_points
//
// A frame takes N load transfers, then N/2*log2 N butterflies, each passing read,
// multiply and write states (one shared multiplier stage), then per bin the serial
// square root (24 steps) that overlaps the CORDIC. Reset: log2_points = 6,
// empty frame. A stalled output holds the bin; no input is taken until the
// whole frame is delivered. A config write drops a partial frame.
module fft_magnitude_phase
    import fftmp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // magnitude, phase_angle, zero fill
    output logic [5:0]  m_axis_tuser,   // bin_index
    output logic        m_axis_tlast
);

    fftmp_cmd_t         cmd;
    logic [2:0]         lp;
    logic [15:0]        magnitude;
    logic signed [16:0] phase_angle;

    fftmp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_data(cfg_data),
        .cfg_ready(cfg_ready), .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
        .out_tready(m_axis_tready), .out_tvalid(m_axis_tvalid),
        .bin_index(m_axis_tuser), .last_bin(m_axis_tlast), .lp(lp), .cmd(cmd)
    );

    fftmp_datapath u_dp (
        .clk(clk), .cmd(cmd), .sample(s_axis_tdata), .lp(lp),
        .magnitude(magnitude), .phase_angle(phase_angle)
    );

    assign m_axis_tdata = {7'd0, phase_angle, magnitude};

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Frame-level check of the FFT magnitude/phase block: random and directed
// sample frames at every transform length, each output bin compared against
// a fixed-point model of the transform, magnitude and phase.
// ----------------------------------------------------------------------------

class fft_bin_board;
    typedef struct {
        logic [5:0]         bin;
        logic [15:0]        mag;
        logic signed [16:0] ph;
        logic               last;
    } bin_t;

    bin_t               pending[$];
    int                 errors;
    int unsigned        log2_pts;
    int unsigned        fill;
    longint             wre[64];
    longint             wim[64];

    function new();
        errors   = 0;
        log2_pts = 6;
        fill     = 0;
    endfunction

    function void set_length(int unsigned v);
        log2_pts = v;
        fill     = 0;
    endfunction

    function automatic longint fdiv(longint v, int s);
        return v >>> s;   // arithmetic shift on signed longint is floor
    endfunction

    function automatic longint sat(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint cosq(int m);
        int t[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330,
                      23170, 20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};
        return t[m];
    endfunction

    function automatic longint root(longint v);
        longint r, b;
        r = 0;
        b = 64'sh4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint angle(longint re, longint im);
        int     atn[15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10,
                            5, 3, 1, 1};
        longint x, y, z, nx, ny;
        if (re == 0) return (im > 0) ? 16384 : ((im < 0) ? -16384 : 0);
        if (im == 0) return (re > 0) ? 0 : 32768;
        x = re * 65536;
        y = im * 65536;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 32768 : -32768;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 15; i++)
        begin
            if (y > 0)
            begin
                nx = x + fdiv(y, i);
                ny = y - fdiv(x, i);
                z += atn[i];
            end
            else
            begin
                nx = x - fdiv(y, i);
                ny = y + fdiv(x, i);
                z -= atn[i];
            end
            x = nx;
            y = ny;
        end
        if (z > 32768) z = 32768;
        if (z < -32768) z = -32768;
        return z;
    endfunction

    // Store one accepted sample; on the frame's last one, transform and queue bins.
    function void note_sample(logic signed [15:0] s);
        int unsigned n, addr, m;
        longint      wr, ws, c, d, tr, ti, pr, pim, mag;
        bin_t        e;
        n    = 1 << log2_pts;
        addr = 0;
        for (int i = 0; i < log2_pts; i++) addr[log2_pts-1-i] = fill[i];
        wre[addr] = s;
        wim[addr] = 0;
        fill++;
        if (fill < n) return;
        fill = 0;
        for (int h = 1; h < n; h = h * 2)
            for (int g = 0; g < n; g += 2 * h)
                for (int j = 0; j < h; j++)
                begin
                    m = (j * (64 / (2 * h))) & 31;
                    if (m <= 16)
                    begin
                        wr = cosq(m);
                        ws = cosq(16 - m);
                    end
                    else
                    begin
                        wr = -cosq(32 - m);
                        ws = cosq(m - 16);
                    end
                    c  = wre[g+j+h];
                    d  = wim[g+j+h];
                    tr = fdiv(c * wr + d * ws + 16384, 15);
                    ti = fdiv(d * wr - c * ws + 16384, 15);
                    pr  = wre[g+j];
                    pim = wim[g+j];
                    wre[g+j]   = sat(pr + tr);
                    wim[g+j]   = sat(pim + ti);
                    wre[g+j+h] = sat(pr - tr);
                    wim[g+j+h] = sat(pim - ti);
                end
        for (int k = 0; k < n; k++)
        begin
            mag = (root(wre[k] * wre[k] + wim[k] * wim[k]) + (n >> 1)) >> log2_pts;
            if (mag > 32768) mag = 32768;
            e.bin  = k;
            e.mag  = mag[15:0];
            e.ph   = angle(wre[k], wim[k]);
            e.last = (k == n - 1);
            pending.push_back(e);
        end
    endfunction

    function void check_bin(logic [5:0] bin, logic [15:0] mag, logic [16:0] ph,
                            logic last);
        bin_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected bin %0d", $time, bin);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (bin !== e.bin)
        begin
            $display("%0t: bin_index expected %0d actual %0d", $time, e.bin, bin);
            errors++;
        end
        if (mag !== e.mag)
        begin
            $display("%0t: magnitude bin %0d expected %0d actual %0d", $time, e.bin,
                     e.mag, mag);
            errors++;
        end
        if (ph !== e.ph)
        begin
            $display("%0t: phase bin %0d expected %0d actual %0d", $time, e.bin,
                     e.ph, $signed(ph));
            errors++;
        end
        if (last !== e.last)
        begin
            $display("%0t: last_bin bin %0d expected %0b actual %0b", $time, e.bin,
                     e.last, last);
            errors++;
        end
    endfunction
endclass

module tb;
    import fftmp_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic [5:0]  m_axis_tuser;
    logic        m_axis_tlast;

    fft_bin_board board = new();
    int           send_idle = 0;   // percent of cycles the sample side holds off
    int           recv_idle = 0;   // percent of cycles the bin side stalls
    int           quiet = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    fft_magnitude_phase dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // Receiver: random stalls, check every bin transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                board.check_bin(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[32:16],
                                m_axis_tlast);
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Hold valid after a transfer; drop it only while idling or draining.
    task automatic send_sample(logic [15:0] s);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        board.note_sample(s);
    endtask

    // Wait for all queued bins, then let the block settle before a write.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_length(logic [2:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        // Out-of-range values clamp to the supported span.
        board.set_length(v < 2 ? 2 : (v > 6 ? 6 : v));
    endtask

    task automatic random_frames(int total);
        for (int i = 0; i < total; i++)
        begin
            case ($urandom_range(3))
                0: send_sample(16'($urandom));
                1: send_sample($urandom_range(1) ? 16'h7fff : 16'h8000);
                2: send_sample(16'($signed($urandom_range(64)) - 32));
                default: send_sample(16'($urandom_range(255) << 8));
            endcase
        end
    endtask

    initial
    begin
        logic [2:0] lens[8] = '{3'd2, 3'd3, 3'd7, 3'd4, 3'd1, 3'd5, 3'd0, 3'd6};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset length, full-scale, impulse, DC, zero, alternating.
        send_sample(16'h7fff);
        send_sample(16'h8000);
        for (int i = 0; i < 62; i++) send_sample(16'h0000);
        write_length(3'd2);
        for (int i = 0; i < 4; i++) send_sample(16'h7fff);
        for (int i = 0; i < 4; i++) send_sample(16'h8000);
        for (int i = 0; i < 4; i++) send_sample(16'h0000);
        for (int i = 0; i < 4; i++) send_sample(i[0] ? 16'h8000 : 16'h7fff);
        send_sample(16'h0001);
        send_sample(16'h0000);
        // Write with a partial frame held drops it.
        write_length(3'd3);
        send_sample(16'h1234);
        write_length(3'd2);
        for (int i = 0; i < 4; i++) send_sample(16'hffff);

        // Random: cycle lengths under the three idle schemes.
        for (int p = 0; p < 3; p++)
        begin
            send_idle = (p == 0) ? 25 : ((p == 1) ? 49 : 0);
            recv_idle = (p == 0) ? 49 : ((p == 1) ? 25 : 0);
            for (int q = 0; q < 5; q++)
            begin
                write_length(lens[(q + p * 5) % 8]);
                random_frames(1 << board.log2_pts);
                if (q == 4) random_frames(3);
            end
        end

        drain();
        if (board.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
